// ----- rtl/itp_pkg.sv -----
// ---------------------------------------------------------------------------
// itp_pkg
// Shared types and codes for the infix to postfix translator.
// ---------------------------------------------------------------------------
package itp_pkg;

    localparam int NUMBER_WIDTH   = 32;
    localparam int POSITION_WIDTH = 16;
    localparam int BURST_DEPTH    = 3;

    // token kinds
    localparam logic [2:0] TK_NUM    = 3'd0;
    localparam logic [2:0] TK_PLUS   = 3'd1;
    localparam logic [2:0] TK_MINUS  = 3'd2;
    localparam logic [2:0] TK_TIMES  = 3'd3;
    localparam logic [2:0] TK_DIVIDE = 3'd4;
    localparam logic [2:0] TK_END    = 3'd5;

    // postfix item kinds
    localparam logic [2:0] IK_PUSH   = 3'd0;
    localparam logic [2:0] IK_ADD    = 3'd1;
    localparam logic [2:0] IK_SUB    = 3'd2;
    localparam logic [2:0] IK_MUL    = 3'd3;
    localparam logic [2:0] IK_DIV    = 3'd4;
    localparam logic [2:0] IK_ACCEPT = 3'd5;
    localparam logic [2:0] IK_ERROR  = 3'd6;

    // error kinds
    localparam logic [1:0] EK_NONE       = 2'd0;
    localparam logic [1:0] EK_NUMBER     = 2'd1;
    localparam logic [1:0] EK_UNEXPECTED = 2'd2;

    // pending operator slot codes
    localparam logic [1:0] PEND_NONE   = 2'd0;
    localparam logic [1:0] PEND_FIRST  = 2'd1;  // add or multiply
    localparam logic [1:0] PEND_SECOND = 2'd2;  // subtract or divide

    typedef enum logic [1:0] {
        PH_OPERAND = 2'd0,
        PH_AFTER   = 2'd1,
        PH_DISCARD = 2'd2
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic [1:0] pend_add;
        logic [1:0] pend_mul;
    } parse_state_t;

    typedef struct packed {
        logic [2:0]                kind;
        logic [NUMBER_WIDTH-1:0]   value;
        logic [1:0]                ekind;
        logic [2:0]                found;
        logic [POSITION_WIDTH-1:0] pos;
        logic                      last;
    } item_t;

    typedef struct packed {
        item_t [BURST_DEPTH-1:0] items;
        logic  [1:0]             count;
    } burst_t;

endpackage

// ----- rtl/itp_step.sv -----
// ---------------------------------------------------------------------------
// itp_step
// Per-token parse step: next parser state and the burst of postfix items.
// ---------------------------------------------------------------------------
module itp_step
(
    input  logic [2:0]                        token_kind,
    input  logic [itp_pkg::NUMBER_WIDTH-1:0]  number_value,
    input  logic [itp_pkg::POSITION_WIDTH-1:0] token_position,
    input  itp_pkg::parse_state_t             st,
    output itp_pkg::parse_state_t             st_next,
    output itp_pkg::burst_t                   burst
);
    import itp_pkg::*;

    function automatic item_t op_item(input logic [2:0] kind);
        item_t it;
        begin
            it      = '0;
            it.kind = kind;
            return it;
        end
    endfunction

    logic       do_flush;
    logic [1:0] flush_ekind;
    logic [1:0] n;
    item_t [BURST_DEPTH-1:0] items;

    always_comb
    begin
        st_next     = st;
        items       = '0;
        n           = 2'd0;
        do_flush    = 1'b0;
        flush_ekind = EK_NONE;

        case (st.phase)
            PH_OPERAND:
            begin
                if (token_kind == TK_NUM)
                begin
                    items[n]       = op_item(IK_PUSH);
                    items[n].value = number_value;
                    n = n + 2'd1;
                    if (st.pend_mul inside {PEND_FIRST, PEND_SECOND})
                    begin
                        items[n] = op_item((st.pend_mul == PEND_SECOND) ? IK_DIV : IK_MUL);
                        n = n + 2'd1;
                    end
                    st_next.pend_mul = PEND_NONE;
                    st_next.phase    = PH_AFTER;
                end
                else
                begin
                    do_flush    = 1'b1;
                    flush_ekind = EK_NUMBER;
                end
            end
            PH_AFTER:
            begin
                if (token_kind inside {TK_TIMES, TK_DIVIDE})
                begin
                    st_next.pend_mul = (token_kind == TK_TIMES) ? PEND_FIRST : PEND_SECOND;
                    st_next.phase    = PH_OPERAND;
                end
                else if (token_kind inside {TK_PLUS, TK_MINUS, TK_END})
                begin
                    if (st.pend_add inside {PEND_FIRST, PEND_SECOND})
                    begin
                        items[n] = op_item((st.pend_add == PEND_SECOND) ? IK_SUB : IK_ADD);
                        n = n + 2'd1;
                    end
                    if (token_kind == TK_END)
                    begin
                        items[n] = op_item(IK_ACCEPT);
                        n = n + 2'd1;
                        st_next.phase    = PH_OPERAND;
                        st_next.pend_add = PEND_NONE;
                        st_next.pend_mul = PEND_NONE;
                    end
                    else
                    begin
                        st_next.pend_add = (token_kind == TK_PLUS) ? PEND_FIRST : PEND_SECOND;
                        st_next.phase    = PH_OPERAND;
                    end
                end
                else
                begin
                    do_flush    = 1'b1;
                    flush_ekind = EK_UNEXPECTED;
                end
            end
            default:
            begin
                // discarding until end of expression
                if (token_kind == TK_END)
                begin
                    st_next.phase    = PH_OPERAND;
                    st_next.pend_add = PEND_NONE;
                    st_next.pend_mul = PEND_NONE;
                end
            end
        endcase

        if (do_flush)
        begin
            // pending multiplicative first, then additive, then the error item
            if (st.pend_mul inside {PEND_FIRST, PEND_SECOND})
            begin
                items[n] = op_item((st.pend_mul == PEND_SECOND) ? IK_DIV : IK_MUL);
                n = n + 2'd1;
            end
            if (st.pend_add inside {PEND_FIRST, PEND_SECOND})
            begin
                items[n] = op_item((st.pend_add == PEND_SECOND) ? IK_SUB : IK_ADD);
                n = n + 2'd1;
            end
            items[n]       = op_item(IK_ERROR);
            items[n].ekind = flush_ekind;
            items[n].found = token_kind;
            items[n].pos   = token_position;
            n = n + 2'd1;
            st_next.pend_add = PEND_NONE;
            st_next.pend_mul = PEND_NONE;
            st_next.phase    = (token_kind == TK_END) ? PH_OPERAND : PH_DISCARD;
        end

        for (int i = 0; i < BURST_DEPTH; i++)
        begin
            if (2'(i) + 2'd1 == n)
            begin
                items[i].last = 1'b1;
            end
        end

        burst.items = items;
        burst.count = n;
    end

endmodule

// ----- rtl/itp_outq.sv -----
// ---------------------------------------------------------------------------
// itp_outq
// Result register: holds one token's burst of items and hands them out in order.
// ---------------------------------------------------------------------------
module itp_outq
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  itp_pkg::burst_t  burst,
    output logic             space,
    output logic             head_valid,
    input  logic             head_ready,
    output itp_pkg::item_t   head
);
    import itp_pkg::*;

    item_t [BURST_DEPTH-1:0] slot_reg;
    item_t [BURST_DEPTH-1:0] slot_next;
    logic  [1:0]             cnt_reg;
    logic  [1:0]             cnt_next;
    logic                    pop;

    assign head_valid = (cnt_reg != 2'd0);
    assign head       = slot_reg[0];
    assign pop        = head_valid & head_ready;
    // a new burst fits once the last held item leaves this cycle
    assign space      = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && head_ready);

    always_comb
    begin
        slot_next = slot_reg;
        cnt_next  = cnt_reg;
        if (load)
        begin
            slot_next = burst.items;
            cnt_next  = burst.count;
        end
        else if (pop)
        begin
            for (int i = 0; i < BURST_DEPTH - 1; i++)
            begin
                slot_next[i] = slot_reg[i+1];
            end
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule

// ----- rtl/infix_to_postfix_expression_translator_core.sv -----
// ---------------------------------------------------------------------------
// infix_to_postfix_expression_translator_core
// Checks a token stream against NUM (op NUM)* END and emits postfix items.
// ---------------------------------------------------------------------------
// One token is taken per cycle while in_ready is high. Each token is parsed
// in the cycle it is accepted and its results (zero to three items) land
// together in a result register that, from the next cycle, drives the output
// channel one item per cycle while out_ready is high. A token with more than
// one result holds the input until only its last is left; tokens that cause
// at most one result stream at one per cycle with out_ready held high. After
// a syntax error, tokens up to and including END are dropped without results.
// ---------------------------------------------------------------------------
module infix_to_postfix_expression_translator_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [2:0]                         token_kind,
    input  logic [itp_pkg::NUMBER_WIDTH-1:0]   number_value,
    input  logic [itp_pkg::POSITION_WIDTH-1:0] token_position,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [2:0]                         item_kind,
    output logic [itp_pkg::NUMBER_WIDTH-1:0]   item_value,
    output logic [1:0]                         error_kind,
    output logic [2:0]                         found_kind,
    output logic [itp_pkg::POSITION_WIDTH-1:0] error_position,
    output logic                               last_of_run
);
    import itp_pkg::*;

    parse_state_t state_reg;
    parse_state_t state_next;
    burst_t       burst;
    item_t        head;
    logic         accept;

    assign accept = in_valid & in_ready;

    itp_step u_step (
        .token_kind     (token_kind),
        .number_value   (number_value),
        .token_position (token_position),
        .st             (state_reg),
        .st_next        (state_next),
        .burst          (burst)
    );

    itp_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .burst      (burst),
        .space      (in_ready),
        .head_valid (out_valid),
        .head_ready (out_ready),
        .head       (head)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase    <= PH_OPERAND;
            state_reg.pend_add <= PEND_NONE;
            state_reg.pend_mul <= PEND_NONE;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    assign item_kind      = head.kind;
    assign item_value     = head.value;
    assign error_kind     = head.ekind;
    assign found_kind     = head.found;
    assign error_position = head.pos;
    assign last_of_run    = head.last;

endmodule

// ----- dv/infix_to_postfix_expression_translator_core_tb.sv -----
// ---------------------------------------------------------------------------
// infix_to_postfix_expression_translator_core_tb
// Streams lexer tokens into the translator and checks every postfix item
// against a parse model kept in the testbench. Directed expressions cover all
// operators, value and position extremes, both error kinds and recovery.
// Random well-formed, broken and noisy expressions follow, with random gaps
// and stalls on both channels and one long output stall.
// ---------------------------------------------------------------------------
module infix_to_postfix_expression_translator_core_tb;
    import itp_pkg::*;

    localparam logic [2:0] TK_LEX_ERR  = 3'd6;
    localparam logic [2:0] TK_OTHER    = 3'd7;
    localparam int         RANDOM_ITEMS = 300;
    localparam int         CYCLE_LIMIT  = 150000;
    localparam int         HOLD_CYCLES  = 200;
    localparam int         DRAIN_CYCLES = 8;

    typedef struct {
        logic [2:0]                kind;
        logic [NUMBER_WIDTH-1:0]   value;
        logic [POSITION_WIDTH-1:0] pos;
    } token_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [2:0]                token_kind = TK_NUM;
    logic [NUMBER_WIDTH-1:0]   number_value = '0;
    logic [POSITION_WIDTH-1:0] token_position = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [2:0]                item_kind;
    logic [NUMBER_WIDTH-1:0]   item_value;
    logic [1:0]                error_kind;
    logic [2:0]                found_kind;
    logic [POSITION_WIDTH-1:0] error_position;
    logic                      last_of_run;

    token_t                    token_backlog[$];
    token_t                    next_token;
    item_t                     postfix_due[$];

    // parse state mirrored from the block
    phase_t                    parse_phase = PH_OPERAND;
    logic [1:0]                held_add = PEND_NONE;
    logic [1:0]                held_mul = PEND_NONE;

    logic [POSITION_WIDTH-1:0] src_pos = '0;
    bit                        calm = 1'b0;
    bit                        hold_request = 1'b0;
    int                        hold_left = 0;
    int                        random_count = 0;
    int                        tokens_sent = 0;
    int                        items_checked = 0;
    int                        accepts_seen = 0;
    int                        syntax_errors_seen = 0;
    int                        mismatch_count = 0;
    int                        cycle_count = 0;

    infix_to_postfix_expression_translator_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .token_kind     (token_kind),
        .number_value   (number_value),
        .token_position (token_position),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .item_kind      (item_kind),
        .item_value     (item_value),
        .error_kind     (error_kind),
        .found_kind     (found_kind),
        .error_position (error_position),
        .last_of_run    (last_of_run)
    );

    always #5 clk = ~clk;

    function automatic item_t make_item(input logic [2:0] kind,
                                        input logic [NUMBER_WIDTH-1:0] value,
                                        input logic [1:0] ekind,
                                        input logic [2:0] found,
                                        input logic [POSITION_WIDTH-1:0] pos);
        item_t it;
        it.kind  = kind;
        it.value = value;
        it.ekind = ekind;
        it.found = found;
        it.pos   = pos;
        it.last  = 1'b0;
        return it;
    endfunction

    function automatic logic [2:0] mul_op(input logic [1:0] slot);
        return (slot == PEND_FIRST) ? IK_MUL : IK_DIV;
    endfunction

    function automatic logic [2:0] add_op(input logic [1:0] slot);
        return (slot == PEND_FIRST) ? IK_ADD : IK_SUB;
    endfunction

    function automatic bit slot_held(input logic [1:0] slot);
        return slot == PEND_FIRST || slot == PEND_SECOND;
    endfunction

    // parse one token and queue the postfix items it produces
    task automatic translate_token(input logic [2:0] kind,
                                   input logic [NUMBER_WIDTH-1:0] value,
                                   input logic [POSITION_WIDTH-1:0] pos);
        item_t      run[$];
        item_t      tail;
        logic [1:0] fault;
        fault = EK_NONE;
        case (parse_phase)
            PH_OPERAND:
            begin
                if (kind == TK_NUM)
                begin
                    run.push_back(make_item(IK_PUSH, value, EK_NONE, '0, '0));
                    if (slot_held(held_mul))
                        run.push_back(make_item(mul_op(held_mul), '0, EK_NONE, '0, '0));
                    held_mul    = PEND_NONE;
                    parse_phase = PH_AFTER;
                end
                else
                    fault = EK_NUMBER;
            end
            PH_AFTER:
            begin
                if (kind == TK_TIMES || kind == TK_DIVIDE)
                begin
                    held_mul    = (kind == TK_TIMES) ? PEND_FIRST : PEND_SECOND;
                    parse_phase = PH_OPERAND;
                end
                else if (kind == TK_PLUS || kind == TK_MINUS)
                begin
                    if (slot_held(held_add))
                        run.push_back(make_item(add_op(held_add), '0, EK_NONE, '0, '0));
                    held_add    = (kind == TK_PLUS) ? PEND_FIRST : PEND_SECOND;
                    parse_phase = PH_OPERAND;
                end
                else if (kind == TK_END)
                begin
                    if (slot_held(held_add))
                        run.push_back(make_item(add_op(held_add), '0, EK_NONE, '0, '0));
                    run.push_back(make_item(IK_ACCEPT, '0, EK_NONE, '0, '0));
                    parse_phase = PH_OPERAND;
                    held_add    = PEND_NONE;
                    held_mul    = PEND_NONE;
                end
                else
                    fault = EK_UNEXPECTED;
            end
            default:
            begin
                // discarding until end, which is dropped too
                if (kind == TK_END)
                begin
                    parse_phase = PH_OPERAND;
                    held_add    = PEND_NONE;
                    held_mul    = PEND_NONE;
                end
            end
        endcase
        if (fault != EK_NONE)
        begin
            if (slot_held(held_mul))
                run.push_back(make_item(mul_op(held_mul), '0, EK_NONE, '0, '0));
            if (slot_held(held_add))
                run.push_back(make_item(add_op(held_add), '0, EK_NONE, '0, '0));
            run.push_back(make_item(IK_ERROR, '0, fault, kind, pos));
            held_mul    = PEND_NONE;
            held_add    = PEND_NONE;
            parse_phase = (kind == TK_END) ? PH_OPERAND : PH_DISCARD;
        end
        if (run.size() != 0)
        begin
            tail      = run.pop_back();
            tail.last = 1'b1;
            run.push_back(tail);
        end
        foreach (run[i])
            postfix_due.push_back(run[i]);
    endtask

    task automatic compare_item;
        item_t want;
        if (postfix_due.size() == 0)
        begin
            $error("unexpected postfix item: item_kind %0d item_value %0h", item_kind,
                   item_value);
            mismatch_count++;
        end
        else
        begin
            want = postfix_due.pop_front();
            if (item_kind !== want.kind)
            begin
                $error("item_kind: expected %0d, got %0d", want.kind, item_kind);
                mismatch_count++;
            end
            if (item_value !== want.value)
            begin
                $error("item_value: expected %0h, got %0h", want.value, item_value);
                mismatch_count++;
            end
            if (error_kind !== want.ekind)
            begin
                $error("error_kind: expected %0d, got %0d", want.ekind, error_kind);
                mismatch_count++;
            end
            if (found_kind !== want.found)
            begin
                $error("found_kind: expected %0d, got %0d", want.found, found_kind);
                mismatch_count++;
            end
            if (error_position !== want.pos)
            begin
                $error("error_position: expected %0h, got %0h", want.pos, error_position);
                mismatch_count++;
            end
            if (last_of_run !== want.last)
            begin
                $error("last_of_run: expected %0b, got %0b", want.last, last_of_run);
                mismatch_count++;
            end
            if (want.kind == IK_ACCEPT)
                accepts_seen++;
            if (want.kind == IK_ERROR)
                syntax_errors_seen++;
        end
        items_checked++;
    endtask

    // token driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                translate_token(token_kind, number_value, token_position);
                tokens_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (token_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 33))
                begin
                    next_token     = token_backlog.pop_front();
                    in_valid       <= 1'b1;
                    token_kind     <= next_token.kind;
                    number_value   <= next_token.value;
                    token_position <= next_token.pos;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // postfix item monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                compare_item();
            if (hold_request)
            begin
                hold_request <= 1'b0;
                hold_left    <= HOLD_CYCLES;
                out_ready    <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= calm || ($urandom_range(0, 99) >= 33);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("infix_to_postfix_expression_translator_core_tb: done, errors");
            $finish;
        end
    end

    function automatic logic [NUMBER_WIDTH-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom();
    endfunction

    task automatic put_token(input logic [2:0] kind, input logic [NUMBER_WIDTH-1:0] value,
                             input logic [POSITION_WIDTH-1:0] pos);
        token_t t;
        t.kind  = kind;
        t.value = value;
        t.pos   = pos;
        token_backlog.push_back(t);
    endtask

    // random token at the running source position
    task automatic put_next(input logic [2:0] kind, input bit counted);
        put_token(kind, pick_value(), src_pos);
        src_pos += POSITION_WIDTH'($urandom_range(1, 700));
        if (counted)
            random_count++;
    endtask

    task automatic gen_expression(input bit broken);
        logic [2:0] seq[$];
        logic [2:0] bad;
        int         nnum;
        int         cut;
        int         junk;
        int         k;
        nnum = $urandom_range(1, 6);
        seq.push_back(TK_NUM);
        for (int j = 1; j < nnum; j++)
        begin
            seq.push_back(TK_PLUS + 3'($urandom_range(0, 3)));
            seq.push_back(TK_NUM);
        end
        seq.push_back(TK_END);
        if (!broken)
        begin
            foreach (seq[i])
                put_next(seq[i], 1'b1);
        end
        else
        begin
            cut = $urandom_range(0, seq.size() - 1);
            // even slots want an operand, odd slots follow a complete term
            if (cut % 2 == 0)
                bad = 3'($urandom_range(1, 7));
            else
            begin
                k   = $urandom_range(0, 2);
                bad = (k == 0) ? TK_NUM : ((k == 1) ? TK_LEX_ERR : TK_OTHER);
            end
            for (int i = 0; i < cut; i++)
                put_next(seq[i], 1'b1);
            put_next(bad, 1'b1);
            if (bad != TK_END)
            begin
                junk = $urandom_range(0, 3);
                for (int i = 0; i < junk; i++)
                begin
                    k = $urandom_range(0, 6);
                    put_next((k >= TK_END) ? 3'(k + 1) : 3'(k), 1'b0);
                end
                put_next(TK_END, 1'b0);
            end
        end
    endtask

    task automatic gen_noise;
        int n;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
            put_next(3'($urandom_range(0, 7)), 1'b1);
        put_next(TK_END, 1'b0);
    endtask

    initial
    begin
        int r;

        // empty expression at the top position
        put_token(TK_END, '0, 16'hFFFF);
        // all four operators with value extremes: 0 + max * 7 - 8 / 9
        put_token(TK_NUM, '0, 16'd0);
        put_token(TK_PLUS, '1, 16'd2);
        put_token(TK_NUM, '1, 16'd4);
        put_token(TK_TIMES, '0, 16'd15);
        put_token(TK_NUM, 32'd7, 16'd17);
        put_token(TK_MINUS, '0, 16'd19);
        put_token(TK_NUM, 32'd8, 16'd21);
        put_token(TK_DIVIDE, '0, 16'd23);
        put_token(TK_NUM, 32'd9, 16'd25);
        put_token(TK_END, '0, 16'd26);
        // missing number with both slots held, then tokens dropped until end
        put_token(TK_NUM, 32'd5, 16'd0);
        put_token(TK_PLUS, '0, 16'd2);
        put_token(TK_NUM, 32'd6, 16'd4);
        put_token(TK_DIVIDE, '0, 16'd6);
        put_token(TK_PLUS, '0, 16'd0);
        put_token(TK_NUM, 32'd7, 16'd10);
        put_token(TK_OTHER, '0, 16'd12);
        put_token(TK_END, '0, 16'd14);
        // number right after a term
        put_token(TK_NUM, 32'd1, 16'd0);
        put_token(TK_NUM, 32'd2, 16'hFFFF);
        put_token(TK_LEX_ERR, '0, 16'd4);
        put_token(TK_END, '0, 16'd6);
        // lexical error after a term
        put_token(TK_NUM, 32'd3, 16'd0);
        put_token(TK_LEX_ERR, '1, 16'h8000);
        put_token(TK_END, '0, 16'd3);
        // other token where a number is due, subtract pending
        put_token(TK_NUM, 32'd4, 16'd0);
        put_token(TK_MINUS, '0, 16'd2);
        put_token(TK_OTHER, '1, 16'h7FFF);
        put_token(TK_END, '0, 16'd6);
        // end where a number is due: back to operand at once
        put_token(TK_NUM, 32'd9, 16'd0);
        put_token(TK_MINUS, '0, 16'd2);
        put_token(TK_END, '0, 16'd4);

        while (random_count < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
                gen_expression(1'b0);
            else if (r < 92)
                gen_expression(1'b1);
            else
                gen_noise();
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // a stretch with no idling, then a long output stall
        while (token_backlog.size() > 250)
            @(negedge clk);
        calm = 1'b1;
        while (token_backlog.size() > 150)
            @(negedge clk);
        calm         = 1'b0;
        hold_request = 1'b1;

        while (token_backlog.size() != 0 || in_valid)
            @(negedge clk);
        while (postfix_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("tokens accepted: %0d, postfix items checked: %0d", tokens_sent,
                 items_checked);
        $display("expressions accepted: %0d, syntax errors reported: %0d", accepts_seen,
                 syntax_errors_seen);
        if (mismatch_count == 0)
            $display("infix_to_postfix_expression_translator_core_tb: done, clean");
        else
            $display("infix_to_postfix_expression_translator_core_tb: done, errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/itp_pkg.sv
rtl/itp_step.sv
rtl/itp_outq.sv
rtl/infix_to_postfix_expression_translator_core.sv
dv/infix_to_postfix_expression_translator_core_tb.sv
